[hdl/rhsv_pkg.sv]
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared widths, constants, sector codes and stage payloads of the
// RGB to HSV converter pipeline.
// ----------------------------------------------------------------------------
package rhsv_pkg;

  localparam int ChanW     = 8;
  localparam int ScW       = 11;
  localparam int PctW      = 7;
  localparam int HueW      = 9;
  localparam int FracW     = 10;
  localparam int SatNumW   = 17;
  localparam int HueNumW   = ScW + FracW;
  localparam int QSatW     = 7;
  localparam int QHueW     = 11;
  localparam int SumW      = 13;
  localparam int DivStages = QHueW;

  localparam logic [SatNumW-1:0] PctScale     = SatNumW'(100);
  localparam logic [ScW-1:0]     GreyLimit    = ScW'(3);
  localparam logic [QSatW-1:0]   LowSatLimit  = QSatW'(3);
  localparam logic [5:0]         DegPerSector = 6'd60;
  localparam logic [SumW-1:0]    OffGreen     = SumW'(2 << 10);
  localparam logic [SumW-1:0]    OffBlue      = SumW'(4 << 10);
  localparam logic [SumW-1:0]    OffRedWrap   = SumW'(6 << 10);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [SatNumW-1:0] sat_rem;
    logic [QSatW-1:0]   sat_q;
    logic [HueNumW-1:0] hue_rem;
    logic [QHueW-1:0]   hue_q;
    logic [ScW-1:0]     mx;
    logic [ScW-1:0]     delta;
    sector_t            sector;
    logic               neg;
    logic               grey;
    logic [PctW-1:0]    val;
  } div_t;

  // floor(c * 1024 / 255) = 4c + floor(4c / 255)
  function automatic logic [ScW-1:0] scale_chan(input logic [ChanW-1:0] c);
    logic [ScW-1:0] base;
    logic [ScW-1:0] corr;
    base = {1'b0, c, 2'b00};
    corr = ScW'(c[7:6]) + ScW'(c == 8'hFF);
    return base + corr;
  endfunction

endpackage

[hdl/rgb_to_hsv_converter_unit.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit
// Streaming 8-bit RGB to integer HSV converter.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while in_stall is low and returns one HSV item
// per pixel, in order, after 3 stages of scaling and max/min, 11 stages of
// pipelined restoring division (one quotient bit per stage, sized by the
// 11-bit hue quotient), and 2 stages of hue scaling ending in the output
// register. The whole pipeline advances together; out_stall holds every
// stage and is passed back as in_stall only while the output register is
// full. The block keeps no state between pixels.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rhsv_pkg::ChanW-1:0]   in_red_in,
  input  logic [rhsv_pkg::ChanW-1:0]   in_green_in,
  input  logic [rhsv_pkg::ChanW-1:0]   in_blue_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rhsv_pkg::HueW-1:0]    out_hue_deg,
  output logic [rhsv_pkg::PctW-1:0]    out_sat_pct,
  output logic [rhsv_pkg::PctW-1:0]    out_val_pct
);
  import rhsv_pkg::*;

  logic adv;
  logic dv_valid, dq_valid;
  div_t dv_data, dq_data;

  // advance when the output register is empty or being taken
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  rhsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_red   (in_red_in),
    .in_green (in_green_in),
    .in_blue  (in_blue_in),
    .dv_valid (dv_valid),
    .dv_data  (dv_data)
  );

  rhsv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .dv_valid (dv_valid),
    .dv_data  (dv_data),
    .dq_valid (dq_valid),
    .dq_data  (dq_data)
  );

  rhsv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .dq_valid  (dq_valid),
    .dq_data   (dq_data),
    .out_valid (out_valid),
    .out_hue   (out_hue_deg),
    .out_sat   (out_sat_pct),
    .out_val   (out_val_pct)
  );

endmodule

[hdl/rhsv_front.sv]
// ----------------------------------------------------------------------------
// rhsv_front
// Channel scaling, max/min and sector pick, then delta, hue difference
// magnitude, saturation dividend and value. Three register stages.
// ----------------------------------------------------------------------------
module rhsv_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic [rhsv_pkg::ChanW-1:0]     in_red,
  input  logic [rhsv_pkg::ChanW-1:0]     in_green,
  input  logic [rhsv_pkg::ChanW-1:0]     in_blue,
  output logic                           dv_valid,
  output rhsv_pkg::div_t                 dv_data
);
  import rhsv_pkg::*;

  logic           s1_valid_r;
  logic [ScW-1:0] r_r, g_r, b_r;
  logic [ScW-1:0] r_nxt, g_nxt, b_nxt;

  logic           s2_valid_r;
  logic [ScW-1:0] mx_r, mn_r, x_r, y_r;
  logic [ScW-1:0] mx_nxt, mn_nxt, x_nxt, y_nxt;
  sector_t        sector_r, sector_nxt;

  logic           s3_valid_r;
  div_t           dv_r, dv_nxt;

  logic [ScW-1:0]     delta;
  logic [ScW-1:0]     mag;
  logic [SatNumW-1:0] val_prod;

  always_comb begin
    r_nxt = scale_chan(in_red);
    g_nxt = scale_chan(in_green);
    b_nxt = scale_chan(in_blue);
  end

  always_comb begin
    priority if (r_r >= g_r && r_r >= b_r) begin
      sector_nxt = SEC_RED;
      mx_nxt     = r_r;
      x_nxt      = g_r;
      y_nxt      = b_r;
    end else if (g_r >= b_r) begin
      sector_nxt = SEC_GREEN;
      mx_nxt     = g_r;
      x_nxt      = b_r;
      y_nxt      = r_r;
    end else begin
      sector_nxt = SEC_BLUE;
      mx_nxt     = b_r;
      x_nxt      = r_r;
      y_nxt      = g_r;
    end
    mn_nxt = r_r;
    if (g_r < mn_nxt) mn_nxt = g_r;
    if (b_r < mn_nxt) mn_nxt = b_r;
  end

  always_comb begin
    delta    = mx_r - mn_r;
    mag      = (x_r < y_r) ? (y_r - x_r) : (x_r - y_r);
    val_prod = SatNumW'(mx_r) * PctScale;
    dv_nxt.sat_rem = SatNumW'(delta) * PctScale;
    dv_nxt.sat_q   = '0;
    dv_nxt.hue_rem = {mag, FracW'(0)};
    dv_nxt.hue_q   = '0;
    dv_nxt.mx      = mx_r;
    dv_nxt.delta   = delta;
    dv_nxt.sector  = sector_r;
    dv_nxt.neg     = (x_r < y_r);
    dv_nxt.grey    = (delta < GreyLimit);
    dv_nxt.val     = val_prod[SatNumW-1 -: PctW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_r      <= r_nxt;
      g_r      <= g_nxt;
      b_r      <= b_nxt;
      mx_r     <= mx_nxt;
      mn_r     <= mn_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      sector_r <= sector_nxt;
      dv_r     <= dv_nxt;
    end
  end

  assign dv_valid = s3_valid_r;
  assign dv_data  = dv_r;

endmodule

[hdl/rhsv_div.sv]
// ----------------------------------------------------------------------------
// rhsv_div
// Pipelined restoring dividers, one quotient bit per stage: hue magnitude
// (11 bits) and saturation (7 bits) run side by side.
// ----------------------------------------------------------------------------
module rhsv_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           dv_valid,
  input  rhsv_pkg::div_t dv_data,
  output logic           dq_valid,
  output rhsv_pkg::div_t dq_data
);
  import rhsv_pkg::*;

  div_t stg_r   [DivStages];
  logic vld_r   [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stg
    localparam int  HB    = QHueW - 1 - k;
    localparam bit  DoSat = (k < QSatW);
    localparam int  SB    = DoSat ? (QSatW - 1 - k) : 0;

    div_t               cur;
    div_t               stg_nxt;
    logic               cur_vld;
    logic [HueNumW-1:0] hue_trial;
    logic [SatNumW-1:0] sat_trial;

    if (k == 0) begin : g_head
      assign cur     = dv_data;
      assign cur_vld = dv_valid;
    end else begin : g_body
      assign cur     = stg_r[k-1];
      assign cur_vld = vld_r[k-1];
    end

    always_comb begin
      stg_nxt   = cur;
      hue_trial = HueNumW'(cur.delta) << HB;
      sat_trial = SatNumW'(cur.mx) << SB;
      if (cur.hue_rem >= hue_trial) begin
        stg_nxt.hue_rem   = cur.hue_rem - hue_trial;
        stg_nxt.hue_q[HB] = 1'b1;
      end
      if (DoSat && cur.sat_rem >= sat_trial) begin
        stg_nxt.sat_rem   = cur.sat_rem - sat_trial;
        stg_nxt.sat_q[SB] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[k] <= stg_nxt;
      end
    end
  end

  assign dq_valid = vld_r[DivStages-1];
  assign dq_data  = stg_r[DivStages-1];

endmodule

[hdl/rhsv_back.sv]
// ----------------------------------------------------------------------------
// rhsv_back
// Signed sector sum, degree scaling and grey / low saturation masking.
// Two register stages; the second is the output register.
// ----------------------------------------------------------------------------
module rhsv_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        dq_valid,
  input  rhsv_pkg::div_t              dq_data,
  output logic                        out_valid,
  output logic [rhsv_pkg::HueW-1:0]   out_hue,
  output logic [rhsv_pkg::PctW-1:0]   out_sat,
  output logic [rhsv_pkg::PctW-1:0]   out_val
);
  import rhsv_pkg::*;

  localparam int ProdW = SumW + 6;

  logic            b1_valid_r;
  logic [SumW-1:0] sum_r, sum_nxt;
  logic            zero_r, zero_nxt;
  logic [PctW-1:0] sat_r, sat_nxt;
  logic [PctW-1:0] val_r;

  logic            out_valid_r;
  logic [HueW-1:0] hue_out_r, hue_out_nxt;
  logic [PctW-1:0] sat_out_r;
  logic [PctW-1:0] val_out_r;

  logic [SumW:0]    qx, sq, off, sum_s;
  logic [ProdW-1:0] deg_prod;

  always_comb begin
    qx = (SumW+1)'(dq_data.hue_q);
    sq = dq_data.neg ? ((SumW+1)'(0) - qx) : qx;
    unique case (dq_data.sector)
      SEC_RED:   off = (SumW+1)'(dq_data.neg ? OffRedWrap : '0);
      SEC_GREEN: off = (SumW+1)'(OffGreen);
      SEC_BLUE:  off = (SumW+1)'(OffBlue);
      default:   off = '0;
    endcase
    sum_s    = sq + off;
    sum_nxt  = sum_s[SumW] ? '0 : sum_s[SumW-1:0];
    zero_nxt = dq_data.grey || (dq_data.sat_q < LowSatLimit);
    sat_nxt  = dq_data.grey ? '0 : dq_data.sat_q;
  end

  always_comb begin
    deg_prod    = ProdW'(sum_r) * ProdW'(DegPerSector);
    hue_out_nxt = zero_r ? '0 : deg_prod[ProdW-1 -: HueW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b1_valid_r  <= dq_valid;
      out_valid_r <= b1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r     <= sum_nxt;
      zero_r    <= zero_nxt;
      sat_r     <= sat_nxt;
      val_r     <= dq_data.val;
      hue_out_r <= hue_out_nxt;
      sat_out_r <= sat_r;
      val_out_r <= val_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hue   = hue_out_r;
  assign out_sat   = sat_out_r;
  assign out_val   = val_out_r;

endmodule
